FILE: rtl/ash3_pkg.sv
// shared types, constants and helper functions of the 3x3 adaptive sharpener
package ash3_pkg;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 4096;
	localparam int QDEPTH         = 4;
	localparam int PIX_W          = 16;
	// floor(s / 9) = (s * AVG_MUL) >> AVG_SHIFT for any 20-bit window sum
	localparam int AVG_MUL        = 3728271;
	localparam int AVG_SHIFT      = 25;
	localparam int MIN_GAIN       = -32;

	typedef enum logic [2:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_STRENGTH     = 3'd2,
		REG_ADAPT        = 3'd3,
		REG_BW_EDGE      = 3'd4,
		REG_BW_NEAR      = 3'd5,
		REG_BLOCK_LIMIT  = 3'd6,
		REG_SAMPLE_BITS  = 3'd7
	} reg_idx_t;

	typedef enum logic {
		CMD_PIXEL = 1'b0,
		CMD_DRAIN = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_RD,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_AVG,
		B_WY,
		B_PROD,
		B_GAIN,
		B_MUL,
		B_OUT
	} back_state_t;

	typedef struct packed {
		logic [11:0]        frame_width;
		logic [12:0]        frame_height;
		logic signed [15:0] strength;
		logic [13:0]        adapt;
		logic [8:0]         bw_edge;
		logic [8:0]         bw_near;
		logic               block_limit;
		logic [4:0]         sample_bits;
	} cfg_t;

	// one output position with its 3x3 neighbourhood, center at index 4
	typedef struct packed {
		logic [8:0][PIX_W-1:0] win;
		logic                  border;
		logic [2:0]            xm;
		logic [2:0]            ym;
		logic                  eol;
		logic                  eof;
	} entry_t;

	function automatic logic [4:0] clamp_bits(input logic [4:0] b);
		logic [4:0] r;
		r = b;
		if (b < 5'd8) r = 5'd8;
		if (b > 5'd16) r = 5'd16;
		return r;
	endfunction

	function automatic logic [PIX_W-1:0] pix_max(input logic [4:0] b);
		logic [16:0] one_sh;
		one_sh = 17'd1 << clamp_bits(b);
		return PIX_W'(one_sh - 17'd1);
	endfunction

endpackage

FILE: rtl/ash3_ram.sv
// generic single-write, single-read memory with registered read data
module ash3_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/ash3_queue.sv
// short item queue between the front and the back
module ash3_queue import ash3_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr,
	input  entry_t wr_data,
	output logic   q_full,
	input  logic   rd,
	output entry_t rd_data,
	output logic   q_empty
);

	localparam int PW = $clog2(QDEPTH);

	entry_t          mem_q [QDEPTH];
	logic [PW-1:0]   wp_q, rp_q;
	logic [PW:0]     cnt_q;

	assign q_full  = (cnt_q == (PW+1)'(QDEPTH));
	assign q_empty = (cnt_q == '0);
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			if (wr && !rd) cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: rtl/ash3_front.sv
// front: takes items, keeps line history and window, tags each output position
module ash3_front import ash3_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic             command,
	input  logic [PIX_W-1:0] pixel,
	input  cfg_t             cfg,
	input  logic             q_full,
	output logic             q_push,
	output entry_t           q_data
);

	localparam int CW = $clog2(MAX_WIDTH + 2);
	localparam int RW = $clog2(MAX_HEIGHT + 2);
	localparam int AW = $clog2(MAX_WIDTH);

	front_state_t     fst_q, fst_n;
	logic [CW-1:0]    in_col_q, out_col_q, cw_q;
	logic [RW-1:0]    in_row_q, out_row_q, ch_q;
	logic [AW-1:0]    col_s1;
	logic [PIX_W-1:0] px_s1;
	logic             col0_s1, emit_s1;
	logic [PIX_W-1:0] win_q [3][3];
	entry_t           ent_q, ent_c;

	logic [PIX_W-1:0] rd1, rd2, px_sat, pmax;
	logic [31:0]      fw32, fh32, cw32, ch32;
	logic [CW-1:0]    cw_use;
	logic [RW-1:0]    ch_use;
	logic             accept, new_frame, pix_phase, cmd_ok;
	logic             eol_c, eof_c;

	// line 1 holds the row above, line 2 the row above that
	ash3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line1 (
		.clk(clk), .we(fst_q == F_RD), .waddr(col_s1), .wdata(px_s1),
		.raddr(in_col_q[AW-1:0]), .rdata(rd1)
	);
	ash3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line2 (
		.clk(clk), .we(fst_q == F_RD), .waddr(col_s1), .wdata(rd1),
		.raddr(in_col_q[AW-1:0]), .rdata(rd2)
	);

	always_comb begin
		fw32 = 32'(cfg.frame_width);
		fh32 = 32'(cfg.frame_height);
		cw32 = (fw32 < 32'd3) ? 32'd3 : ((fw32 > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : fw32);
		ch32 = (fh32 < 32'd3) ? 32'd3 : ((fh32 > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : fh32);
		new_frame = (in_row_q == '0) && (in_col_q == '0) && (command == CMD_PIXEL);
		cw_use    = new_frame ? CW'(cw32) : cw_q;
		ch_use    = new_frame ? RW'(ch32) : ch_q;
		pix_phase = in_row_q < ch_use;
		cmd_ok    = pix_phase ? (command == CMD_PIXEL) : (command == CMD_DRAIN);
		pmax      = pix_max(cfg.sample_bits);
		px_sat    = (pixel > pmax) ? pmax : pixel;
		accept    = push && !full;
	end

	always_comb begin
		fst_n  = fst_q;
		full   = (fst_q != F_IDLE);
		q_push = 1'b0;
		case (fst_q)
			F_IDLE: begin
				if (accept && cmd_ok) fst_n = F_RD;
			end
			F_RD: begin
				fst_n = emit_s1 ? F_PUSH : F_IDLE;
			end
			F_PUSH: begin
				if (!q_full) begin
					q_push = 1'b1;
					fst_n  = F_IDLE;
				end
			end
			default: fst_n = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q <= F_IDLE;
		end else begin
			fst_q <= fst_n;
		end
	end

	// window after this item's shift, center taken from the old one at column zero
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 2; c++) begin
				ent_c.win[r*3+c] = win_q[r][c+1];
			end
		end
		ent_c.win[2] = rd2;
		ent_c.win[5] = rd1;
		ent_c.win[8] = px_s1;
		if (col0_s1) ent_c.win[4] = win_q[1][2];
		eol_c        = (out_col_q == CW'(cw_q - 1'b1));
		eof_c        = eol_c && (out_row_q == RW'(ch_q - 1'b1));
		ent_c.eol    = eol_c;
		ent_c.eof    = eof_c;
		ent_c.border = (out_col_q == '0) || (out_row_q == '0) || eol_c ||
			(out_row_q == RW'(ch_q - 1'b1));
		ent_c.xm     = out_col_q[2:0];
		ent_c.ym     = out_row_q[2:0];
	end

	assign q_data = ent_q;

	always_ff @(posedge clk) begin
		if (fst_q == F_IDLE && accept && cmd_ok) begin
			col_s1  <= in_col_q[AW-1:0];
			px_s1   <= pix_phase ? px_sat : '0;
			col0_s1 <= (in_col_q == '0) || (in_col_q == cw_use);
			emit_s1 <= pix_phase ? ((in_row_q > RW'(1)) ||
				((in_row_q == RW'(1)) && (in_col_q != '0))) : 1'b1;
		end
		if (fst_q == F_RD) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= rd2;
			win_q[1][2] <= rd1;
			win_q[2][2] <= px_s1;
			ent_q       <= ent_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			cw_q      <= CW'(3);
			ch_q      <= RW'(3);
		end else begin
			if (fst_q == F_IDLE && accept) begin
				if (new_frame) begin
					cw_q <= cw_use;
					ch_q <= ch_use;
				end
				if (cmd_ok) begin
					if (pix_phase) begin
						if (in_col_q + 1'b1 == cw_use) begin
							in_col_q <= '0;
							in_row_q <= in_row_q + 1'b1;
						end else begin
							in_col_q <= in_col_q + 1'b1;
						end
					end else begin
						if (in_col_q == cw_use) begin
							in_col_q <= '0;
							in_row_q <= '0;
						end else begin
							in_col_q <= in_col_q + 1'b1;
						end
					end
				end
			end
			if (fst_q == F_RD && emit_s1) begin
				if (out_col_q + 1'b1 == cw_q) begin
					out_col_q <= '0;
					if (out_row_q + 1'b1 == ch_q) out_row_q <= '0;
					else out_row_q <= out_row_q + 1'b1;
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end
		end
	end

endmodule

FILE: rtl/ash3_back.sv
// back: mean, deviation, adaptive gain and clamp, one step per cycle unless the queue is empty or the output is held
module ash3_back import ash3_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             q_empty,
	input  entry_t           q_head,
	output logic             q_pop,
	output logic             empty,
	input  logic             pop,
	output logic [PIX_W-1:0] out_pixel,
	output logic             end_of_line,
	output logic             end_of_frame
);

	back_state_t       bst_q, bst_n;
	logic [PIX_W-1:0]  c_q, dev_q, avg_q;
	logic [19:0]       sum_q;
	logic [2:0]        xm_q, ym_q;
	logic              border_q, eol_q, eof_q;
	logic [15:0]       d2_q;
	logic [38:0]       p_q;
	logic signed [16:0] t2_q;
	logic signed [33:0] m_q;
	logic              ovalid_q;

	logic [19:0]       sum_c;
	logic [PIX_W-1:0]  dev_c, a_c, avg_c, pmax;
	logic [41:0]       avg_prod;
	logic              skip, wt_en, take;
	logic [8:0]        xf, yf;
	logic              xf_en, yf_en;
	logic [15:0]       d2x_c, d2y_c;
	logic [4:0]        bits;
	logic [38:0]       q_sh;
	logic signed [31:0] t_c, str32, da;
	logic signed [16:0] diff_c;
	logic signed [24:0] sh_c;
	logic signed [35:0] res_c;
	logic [PIX_W-1:0]  res_pix;

	// window sum and largest neighbour deviation, block edges masked when asked
	always_comb begin
		sum_c = '0;
		dev_c = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				sum_c = sum_c + 20'(q_head.win[r*3+c]);
				skip  = (r == 1) && (c == 1);
				if (cfg.block_limit) begin
					if (r == 0 && q_head.ym == 3'd0) skip = 1'b1;
					if (r == 2 && q_head.ym == 3'd7) skip = 1'b1;
					if (c == 0 && q_head.xm == 3'd0) skip = 1'b1;
					if (c == 2 && q_head.xm == 3'd7) skip = 1'b1;
				end
				a_c = (q_head.win[r*3+c] >= q_head.win[4]) ?
					q_head.win[r*3+c] - q_head.win[4] : q_head.win[4] - q_head.win[r*3+c];
				if (!skip && a_c > dev_c) dev_c = a_c;
			end
		end
	end

	always_comb begin
		bits     = clamp_bits(cfg.sample_bits);
		pmax     = pix_max(cfg.sample_bits);
		avg_prod = 42'(sum_q) * 42'(AVG_MUL);
		avg_c    = avg_prod[AVG_SHIFT+PIX_W-1:AVG_SHIFT];
		wt_en    = (cfg.bw_near != 9'd256) && (cfg.bw_edge != 9'd256);
		xf_en    = 1'b0;
		xf       = cfg.bw_near;
		if (xm_q inside {3'd1, 3'd6}) begin
			xf_en = wt_en;
			xf    = cfg.bw_near;
		end else if (xm_q inside {3'd0, 3'd7}) begin
			xf_en = wt_en;
			xf    = cfg.bw_edge;
		end
		yf_en = 1'b0;
		yf    = cfg.bw_near;
		if (ym_q inside {3'd1, 3'd6}) begin
			yf_en = wt_en;
			yf    = cfg.bw_near;
		end else if (ym_q inside {3'd0, 3'd7}) begin
			yf_en = wt_en;
			yf    = cfg.bw_edge;
		end
		d2x_c = xf_en ? 16'((23'(cfg.adapt) * 23'(xf)) >> 8) : 16'(cfg.adapt);
		d2y_c = yf_en ? 16'((25'(d2_q) * 25'(yf)) >> 8) : d2_q;

		q_sh  = p_q >> (5'd8 + bits);
		da    = $signed(32'(cfg.adapt[13:7])) + 32'(MIN_GAIN);
		str32 = 32'(cfg.strength);
		t_c   = (cfg.adapt == '0) ? str32 : (($signed(32'(q_sh)) + da) <<< 4);
		if (t_c > str32) t_c = str32;
		if (t_c < 32'(MIN_GAIN)) t_c = 32'(MIN_GAIN);

		diff_c = $signed({1'b0, c_q}) - $signed({1'b0, avg_q});
		// gain is scaled by 128 / 65536, so the product shifts right by nine
		sh_c   = 25'(m_q >>> 9);
		res_c  = 36'(sh_c) + $signed({20'd0, c_q});
		if (border_q) res_pix = c_q;
		else if (res_c < 0) res_pix = '0;
		else if (res_c > $signed({20'd0, pmax})) res_pix = pmax;
		else res_pix = PIX_W'(res_c);
	end

	assign take = !ovalid_q || pop;

	always_comb begin
		bst_n = bst_q;
		q_pop = 1'b0;
		case (bst_q)
			B_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					bst_n = q_head.border ? B_OUT : B_AVG;
				end
			end
			B_AVG:  bst_n = B_WY;
			B_WY:   bst_n = B_PROD;
			B_PROD: bst_n = B_GAIN;
			B_GAIN: bst_n = B_MUL;
			B_MUL:  bst_n = B_OUT;
			B_OUT: begin
				if (take) bst_n = B_IDLE;
			end
			default: bst_n = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q    <= B_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			bst_q <= bst_n;
			if (bst_q == B_OUT && take) ovalid_q <= 1'b1;
			else if (pop) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (bst_q)
			B_IDLE: begin
				c_q      <= q_head.win[4];
				sum_q    <= sum_c;
				dev_q    <= dev_c;
				xm_q     <= q_head.xm;
				ym_q     <= q_head.ym;
				border_q <= q_head.border;
				eol_q    <= q_head.eol;
				eof_q    <= q_head.eof;
			end
			B_AVG: begin
				avg_q <= avg_c;
				d2_q  <= d2x_c;
			end
			B_WY:   d2_q <= d2y_c;
			B_PROD: p_q  <= 39'({dev_q, 7'd0}) * 39'(d2_q);
			B_GAIN: t2_q <= 17'(t_c);
			B_MUL:  m_q  <= 34'(diff_c) * 34'(t2_q);
			B_OUT: begin
				if (take) begin
					out_pixel    <= res_pix;
					end_of_line  <= eol_q;
					end_of_frame <= eof_q;
				end
			end
			default: ;
		endcase
	end

	assign empty = !ovalid_q;

endmodule

FILE: rtl/adaptive_sharpen_3x3.sv
// top level of the 3x3 adaptive sharpener: register file, front, queue and back
// Luma pixels enter in raster order and each sharpened pixel leaves one row plus one pixel
// later; after a frame, frame_width + 1 drain items (command 1) push out the last results.
// Rows 0 and H-1 and columns 0 and W-1 pass through unchanged. The front takes an item that
// yields a result by line-memory read, window shift and queue write, any other item by
// the first two, and drops an item of the wrong kind; the back takes an interior pixel
// through sum and deviation, mean with the column weight, row weight, deviation product,
// gain clamp, final product and output register, a border pixel from sum and deviation
// straight to the output register, and neither side takes an item before the last is done.
// A four-item queue between them and an output register let either side stall alone. Frame
// size is taken at the first pixel of a frame; write registers only while the block is idle.
module adaptive_sharpen_3x3 import ash3_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic             command,
	input  logic [PIX_W-1:0] pixel,
	output logic             empty,
	input  logic             pop,
	output logic [PIX_W-1:0] out_pixel,
	output logic             end_of_line,
	output logic             end_of_frame,
	input  logic             wr_en,
	input  logic [2:0]       wr_index,
	input  logic [15:0]      wr_data
);

	cfg_t   cfg_q;
	entry_t q_in, q_head;
	logic   q_push, q_pop, q_full, q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= 12'd1920;
			cfg_q.frame_height <= 13'd1080;
			cfg_q.strength     <= 16'sd1024;
			cfg_q.adapt        <= 14'd2048;
			cfg_q.bw_edge      <= 9'd256;
			cfg_q.bw_near      <= 9'd256;
			cfg_q.block_limit  <= 1'b0;
			cfg_q.sample_bits  <= 5'd8;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= wr_data[11:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= wr_data[12:0];
				REG_STRENGTH:     cfg_q.strength     <= $signed(wr_data);
				REG_ADAPT:        cfg_q.adapt        <= wr_data[13:0];
				REG_BW_EDGE:      cfg_q.bw_edge      <= wr_data[8:0];
				REG_BW_NEAR:      cfg_q.bw_near      <= wr_data[8:0];
				REG_BLOCK_LIMIT:  cfg_q.block_limit  <= wr_data[0];
				REG_SAMPLE_BITS:  cfg_q.sample_bits  <= wr_data[4:0];
				default: ;
			endcase
		end
	end

	ash3_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.command(command), .pixel(pixel), .cfg(cfg_q),
		.q_full(q_full), .q_push(q_push), .q_data(q_in)
	);

	ash3_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(q_push), .wr_data(q_in), .q_full(q_full),
		.rd(q_pop), .rd_data(q_head), .q_empty(q_empty)
	);

	ash3_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .q_empty(q_empty), .q_head(q_head),
		.q_pop(q_pop), .empty(empty), .pop(pop), .out_pixel(out_pixel),
		.end_of_line(end_of_line), .end_of_frame(end_of_frame)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("item written into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("item taken from an empty queue");

	a_eof_eol: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && end_of_frame) |-> end_of_line) else $error("frame end off a line end");

	a_pop_refill: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> !q_pop) else $error("back took two items in successive cycles");

endmodule
